// File: hdl/cbsm_pkg.sv
`default_nettype none

package cbsm_pkg;

    // Field widths of the bus side and of the image side.
    localparam int OFFSET_W = 16;
    localparam int DATA_W   = 8;
    localparam int BASE_W   = 18;
    localparam int TYPE_W   = 16;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CART_TYPE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CART_IS_64K = CFG_INDEX_W'(1);

    // Bus function codes.
    localparam logic FUNC_CART = 1'b0;
    localparam logic FUNC_TIA  = 1'b1;

    // TIA register that carries the lock, top select and video bits.
    localparam logic [OFFSET_W-1:0] TIA_CTRL_REG = 16'h0001;

    // Cartridge type bits and whole-word mapper codes.
    localparam int TYPE_BIT_SOUND = 0;
    localparam int TYPE_BIT_SUPER = 1;
    localparam int TYPE_BIT_RAM   = 2;
    localparam logic [TYPE_W-1:0] TYPE_ABSOLUTE = 16'h0200;
    localparam logic [TYPE_W-1:0] TYPE_ADDR_SEL = 16'h0100;

    // Address boundaries.
    localparam logic [OFFSET_W-1:0] OFF_HIGH_START  = 16'h4000;
    localparam logic [OFFSET_W-1:0] OFF_ADDR_SEL_LO = 16'hBF80;

    // Bank masks.
    localparam logic [2:0] BANK_MASK_64K = 3'h3;
    localparam logic [2:0] BANK_MASK_BIG = 3'h7;

    // Image offsets.
    localparam logic [BASE_W-1:0] IMG_BANK_LO  = 18'h10000;
    localparam logic [BASE_W-1:0] IMG_BANK_HI  = 18'h12000;
    localparam logic [BASE_W-1:0] IMG_ABS_ALT  = 18'h14000;
    localparam int                BANK_SHIFT   = 14;

    // Window reset values.
    localparam logic [BASE_W-1:0] WIN1_RESET = 18'h04000;
    localparam logic [BASE_W-1:0] WIN2_RESET = 18'h08000;
    localparam logic [BASE_W-1:0] WIN3_RESET = 18'h0A000;
    localparam logic [BASE_W-1:0] WIN4_RESET = 18'h0C000;

    // One bus write.
    typedef struct packed {
        logic                func;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   wdata;
    } t_item;

    // Mapper state.
    typedef struct packed {
        logic [BASE_W-1:0] window1;
        logic [BASE_W-1:0] window2;
        logic [BASE_W-1:0] window3;
        logic [BASE_W-1:0] window4;
        logic              lock;
        logic              cart_sel;
        logic              video;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [BASE_W-1:0]   window1_base;
        logic [BASE_W-1:0]   window2_base;
        logic [BASE_W-1:0]   window3_base;
        logic [BASE_W-1:0]   window4_base;
        logic                ram_write;
        logic                sound_write;
        logic                undefined_write;
        logic [OFFSET_W-1:0] target_offset;
        logic [DATA_W-1:0]   target_data;
        logic                cart_at_top;
        logic                ctrl_locked;
        logic                video_enabled;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/cbsm_if.sv
`default_nettype none

// Bus write channel.
interface cbsm_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] offset;
    logic [7:0]  wdata;

    modport source (output valid, output func, output offset, output wdata, input ready);
    modport sink   (input valid, input func, input offset, input wdata, output ready);
endinterface

// Result channel.
interface cbsm_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] window1_base;
    logic [17:0] window2_base;
    logic [17:0] window3_base;
    logic [17:0] window4_base;
    logic        ram_write;
    logic        sound_write;
    logic        undefined_write;
    logic [15:0] target_offset;
    logic [7:0]  target_data;
    logic        cart_at_top;
    logic        ctrl_locked;
    logic        video_enabled;

    modport source (
        output valid, input ready,
        output window1_base, output window2_base, output window3_base, output window4_base,
        output ram_write, output sound_write, output undefined_write,
        output target_offset, output target_data,
        output cart_at_top, output ctrl_locked, output video_enabled
    );
    modport sink (
        input valid, output ready,
        input window1_base, input window2_base, input window3_base, input window4_base,
        input ram_write, input sound_write, input undefined_write,
        input target_offset, input target_data,
        input cart_at_top, input ctrl_locked, input video_enabled
    );
endinterface

// Configuration write channel.
interface cbsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cbsm_next.sv
`default_nettype none

// Decodes one bus write against the current mapper state and produces the
// next state together with the result item.
module cbsm_next (
    input  wire cbsm_pkg::t_state                  i_state,
    input  wire logic [cbsm_pkg::TYPE_W-1:0]       i_cart_type,
    input  wire logic                              i_cart_is_64k,
    input  wire cbsm_pkg::t_item                   i_item,
    output cbsm_pkg::t_state                       o_state,
    output cbsm_pkg::t_result                      o_result
);
    import cbsm_pkg::*;

    always_comb begin
        t_state            nxt;
        logic              low_write;
        logic              is_high;
        logic [2:0]        super_bank;
        logic [2:0]        addr_bank;
        logic [BASE_W-1:0] super_add;
        logic [BASE_W-1:0] addr_add;

        nxt        = i_state;
        is_high    = (i_item.offset >= OFF_HIGH_START);
        low_write  = (i_item.func == FUNC_CART) && !is_high;
        super_bank = i_item.wdata[2:0] & (i_cart_is_64k ? BANK_MASK_64K : BANK_MASK_BIG);
        addr_bank  = i_item.offset[2:0];
        super_add  = BASE_W'({super_bank, BANK_SHIFT'(0)});
        addr_add   = BASE_W'({addr_bank, BANK_SHIFT'(0)});

        // Strobes for low cartridge writes; RAM takes precedence over sound.
        o_result.ram_write       = low_write && i_cart_type[TYPE_BIT_RAM];
        o_result.sound_write     = low_write && !i_cart_type[TYPE_BIT_RAM]
                                   && i_cart_type[TYPE_BIT_SOUND];
        o_result.undefined_write = low_write && !i_cart_type[TYPE_BIT_RAM]
                                   && !i_cart_type[TYPE_BIT_SOUND];
        if (o_result.ram_write || o_result.sound_write) begin
            o_result.target_offset = i_item.offset;
            o_result.target_data   = i_item.wdata;
        end else begin
            o_result.target_offset = '0;
            o_result.target_data   = '0;
        end

        if (i_item.func == FUNC_TIA) begin
            // Control register: video is sticky, lock freezes the rest.
            if (i_item.offset == TIA_CTRL_REG) begin
                if (i_item.wdata[0]) begin
                    nxt.video = 1'b1;
                end
                if (!i_state.lock) begin
                    nxt.lock     = i_item.wdata[0];
                    nxt.cart_sel = i_item.wdata[2];
                end
            end
        end else begin
            // Bank switching, one scheme per write.
            if (i_cart_type[TYPE_BIT_SUPER] && is_high) begin
                nxt.window2 = IMG_BANK_LO + super_add;
                nxt.window3 = IMG_BANK_HI + super_add;
            end else if (i_cart_type == TYPE_ABSOLUTE && i_item.offset == OFF_HIGH_START) begin
                if (i_item.wdata[0]) begin
                    nxt.window1 = IMG_BANK_LO;
                end else if (i_item.wdata[1]) begin
                    nxt.window1 = IMG_ABS_ALT;
                end
            end else if (i_cart_type == TYPE_ADDR_SEL && i_item.offset >= OFF_ADDR_SEL_LO) begin
                nxt.window3 = IMG_BANK_LO + addr_add;
                nxt.window4 = IMG_BANK_HI + addr_add;
            end
        end

        o_state               = nxt;
        o_result.window1_base = nxt.window1;
        o_result.window2_base = nxt.window2;
        o_result.window3_base = nxt.window3;
        o_result.window4_base = nxt.window4;
        o_result.cart_at_top  = nxt.cart_sel;
        o_result.ctrl_locked  = nxt.lock;
        o_result.video_enabled = nxt.video;
    end

endmodule

`default_nettype wire

// File: hdl/cartridge_bank_switch_mapper.sv
`default_nettype none

// Cartridge bank-switch mapper. Each bus write accepted on i_in yields
// exactly one result item on o_out carrying the four window base offsets,
// the RAM, sound and undefined strobes with their target, and the top,
// lock and video flags as they stand after that write. One write is
// accepted every cycle while results are taken; a write is captured in
// an input register when it is accepted and passes the decode logic into
// the result register once that one is empty or being taken, and its
// result is offered from there on o_out. The input register keeps taking
// one further write while a result waits on o_out.
// Configuration writes on i_cfg are always ready and are meant to be made
// while no write is in flight.
module cartridge_bank_switch_mapper (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbsm_in_if.sink    i_in,
    cbsm_out_if.source o_out,
    cbsm_cfg_if.sink   i_cfg
);
    import cbsm_pkg::*;

    logic [TYPE_W-1:0] r_cart_type;
    logic              r_cart_is_64k;
    t_state            r_state;
    t_state            n_state;
    t_item             r_item;
    logic              r_item_valid;
    t_result           r_result;
    t_result           n_result;
    logic              r_out_valid;
    logic              in_accept;
    logic              advance;

    // Handshake: the input register drains into the result register when
    // that one is empty or being taken.
    assign advance    = r_item_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_item_valid || advance;
    assign in_accept  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_type   <= '0;
            r_cart_is_64k <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_CART_TYPE) begin
                r_cart_type <= i_cfg.data;
            end
            if (i_cfg.index == REG_CART_IS_64K) begin
                r_cart_is_64k <= i_cfg.data[0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= in_accept || (r_item_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.func   <= i_in.func;
            r_item.offset <= i_in.offset;
            r_item.wdata  <= i_in.wdata;
        end
    end

    cbsm_next u_next (
        .i_state       (r_state),
        .i_cart_type   (r_cart_type),
        .i_cart_is_64k (r_cart_is_64k),
        .i_item        (r_item),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Mapper state advances with each write that moves to the result side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window1  <= WIN1_RESET;
            r_state.window2  <= WIN2_RESET;
            r_state.window3  <= WIN3_RESET;
            r_state.window4  <= WIN4_RESET;
            r_state.lock     <= 1'b0;
            r_state.cart_sel <= 1'b0;
            r_state.video    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.window1_base    = r_result.window1_base;
    assign o_out.window2_base    = r_result.window2_base;
    assign o_out.window3_base    = r_result.window3_base;
    assign o_out.window4_base    = r_result.window4_base;
    assign o_out.ram_write       = r_result.ram_write;
    assign o_out.sound_write     = r_result.sound_write;
    assign o_out.undefined_write = r_result.undefined_write;
    assign o_out.target_offset   = r_result.target_offset;
    assign o_out.target_data     = r_result.target_data;
    assign o_out.cart_at_top     = r_result.cart_at_top;
    assign o_out.ctrl_locked     = r_result.ctrl_locked;
    assign o_out.video_enabled   = r_result.video_enabled;

    // Once set, the lock never clears until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lock |=> r_state.lock)
        else $error("control lock cleared");

    // While locked, the top selection does not move.
    a_top_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lock |=> $stable(r_state.cart_sel))
        else $error("top selection changed while locked");

    // The video flag is sticky.
    a_video_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.video |=> r_state.video)
        else $error("video flag cleared");

    // A new result only appears from a write held in the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_item_valid))
        else $error("result without a pending write");

    // State changes only when a write moves to the result side.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("mapper state changed without a write");

endmodule

`default_nettype wire
